>>> rtl/clex_pkg.sv
// Shared types, widths, token kind codes and keyword tables for the lexer.
// No dependencies; every other lexer file imports this package.
`default_nettype none

package clex_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int KIND_W = 4;
    localparam int OFFS_W = 32;
    localparam int LEN_W  = 8;
    localparam int LINE_W = 32;
    localparam int CFG_W  = 16;

    // Defaults for top-level parameters.
    localparam int DEF_MAX_TOKEN_LEN = 255;
    localparam int DEF_QUEUE_DEPTH   = 4;

    // Line counter value after reset.
    localparam logic [LINE_W-1:0] LINE_RESET = LINE_W'(1);

    // Token kind codes.
    localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_COMMA      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_SEMI       = 4'd2;
    localparam logic [KIND_W-1:0] KIND_LPAREN     = 4'd3;
    localparam logic [KIND_W-1:0] KIND_RPAREN     = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LBRACKET   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RBRACKET   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_LBRACE     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_RBRACE     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_INTROSPECT = 4'd9;
    localparam logic [KIND_W-1:0] KIND_STRING     = 4'd13;
    localparam logic [KIND_W-1:0] KIND_IDENT      = 4'd14;
    localparam logic [KIND_W-1:0] KIND_EOF        = 4'd15;

    // Keyword choice codes (same order as the keyword kind codes).
    localparam logic [1:0] KW_INTROSPECT = 2'd0;
    localparam logic [1:0] KW_STRUCT     = 2'd1;
    localparam logic [1:0] KW_ENUM       = 2'd2;
    localparam logic [1:0] KW_UNION      = 2'd3;

    // Keyword spellings, left aligned in ten character slots.
    localparam logic [79:0] KW_TEXT_INTROSPECT = "introspect";
    localparam logic [79:0] KW_TEXT_STRUCT     = {"struct", 32'h0};
    localparam logic [79:0] KW_TEXT_ENUM       = {"enum", 48'h0};
    localparam logic [79:0] KW_TEXT_UNION      = {"union", 40'h0};

    // One token as it travels from the front end to the output stage.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFFS_W-1:0] start;
        logic [LEN_W-1:0]  len;
        logic [LINE_W-1:0] line;
        logic              runaway;
    } token_t;

    // All tokens caused by one byte: one or two.
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } entry_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Spelling length of a keyword.
    function automatic logic [3:0] kw_len(input logic [1:0] choice);
        logic [3:0] res;
        case (choice)
            KW_INTROSPECT: res = 4'd10;
            KW_STRUCT:     res = 4'd6;
            KW_ENUM:       res = 4'd4;
            KW_UNION:      res = 4'd5;
            default:       res = 4'd0;
        endcase
        return res;
    endfunction

    // Character at a position of a keyword; zero past the tenth character.
    function automatic logic [7:0] kw_char(input logic [1:0] choice, input logic [3:0] pos);
        logic [79:0] text;
        logic [79:0] shifted;
        case (choice)
            KW_INTROSPECT: text = KW_TEXT_INTROSPECT;
            KW_STRUCT:     text = KW_TEXT_STRUCT;
            KW_ENUM:       text = KW_TEXT_ENUM;
            KW_UNION:      text = KW_TEXT_UNION;
            default:       text = '0;
        endcase
        shifted = text << {pos, 3'b000};
        return (pos > 4'd9) ? 8'h00 : shifted[79:72];
    endfunction

endpackage

`default_nettype wire

>>> rtl/clex_if.sv
// Handshake channels of the lexer: source bytes, tokens and configuration.
// Uses widths from clex_pkg.
`default_nettype none

interface clex_byte_if;
    import clex_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] source_byte;
    logic              end_of_input;

    modport source (output valid, output source_byte, output end_of_input, input ready);
    modport sink   (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface clex_token_if;
    import clex_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;
    logic [OFFS_W-1:0] start_offset;
    logic [LEN_W-1:0]  token_length;
    logic [LINE_W-1:0] line_number;
    logic              runaway_comment;
    logic              last_result;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output line_number, output runaway_comment,
                    output last_result, input ready);
    modport sink   (input valid, input token_kind, input start_offset,
                    input token_length, input line_number, input runaway_comment,
                    input last_result, output ready);
endinterface

interface clex_cfg_if;
    import clex_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] first_line;

    modport source (output valid, output first_line, input ready);
    modport sink   (input valid, input first_line, output ready);
endinterface

`default_nettype wire

>>> rtl/clex_front.sv
// Front end of the lexer: accepts one byte per cycle while the queue is not full, runs the lexing state
// machine and writes the tokens each byte causes into the queue. Uses clex_pkg.
`default_nettype none

module clex_front
    import clex_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    clex_byte_if.sink       text,
    clex_cfg_if.sink        cfg,
    input  wire q_status_t  q_stat,
    output logic            push,
    output entry_t          entry
);

    // Lexer modes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_SLASH   = 3'd1;
    localparam logic [2:0] MODE_LINE    = 3'd2;
    localparam logic [2:0] MODE_BLOCK   = 3'd3;
    localparam logic [2:0] MODE_STAR    = 3'd4;
    localparam logic [2:0] MODE_KEYWORD = 3'd5;
    localparam logic [2:0] MODE_IDENT   = 3'd6;
    localparam logic [2:0] MODE_STRING  = 3'd7;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_I        = 8'h69;
    localparam logic [7:0] CH_S        = 8'h73;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_U        = 8'h75;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LEN);

    logic [2:0]        mode_reg, mode_next;
    logic [3:0]        kw_prog_reg, kw_prog_next;
    logic [1:0]        kw_choice_reg, kw_choice_next;
    logic [OFFS_W-1:0] tok_start_reg, tok_start_next;
    logic [LEN_W-1:0]  tok_len_reg, tok_len_next;
    logic [LINE_W-1:0] tok_line_reg, tok_line_next;
    logic [OFFS_W-1:0] offset_reg, offset_next;
    logic [LINE_W-1:0] line_count_reg, line_count_next;
    logic              esc_reg, esc_next;

    logic              accept;
    logic [7:0]        b;
    logic              emit_a, emit_b;
    token_t            tok_a, tok_b;

    assign text.ready = !q_stat.full;
    assign cfg.ready  = 1'b1;
    assign accept     = text.valid && text.ready;
    assign b          = text.source_byte;

    // Next lexer state and the tokens of this byte. Slot a holds a token that
    // closes a pending identifier, keyword or string; slot b holds the token
    // of the byte itself when lexed from the idle mode, or the end-of-input token.
    always_comb
    begin
        logic       go_idle;
        logic       ident_path;
        logic       kw_match;
        logic [3:0] kw_prog_inc;
        logic [LEN_W-1:0] len_grown;
        logic       punct;
        logic [KIND_W-1:0] punct_kind;
        logic       is_alpha;
        logic       is_digit;
        logic       is_space;

        mode_next       = mode_reg;
        kw_prog_next    = kw_prog_reg;
        kw_choice_next  = kw_choice_reg;
        tok_start_next  = tok_start_reg;
        tok_len_next    = tok_len_reg;
        tok_line_next   = tok_line_reg;
        offset_next     = offset_reg;
        line_count_next = line_count_reg;
        esc_next        = esc_reg;
        emit_a          = 1'b0;
        emit_b          = 1'b0;
        tok_a           = '0;
        tok_b           = '0;
        go_idle         = 1'b0;
        ident_path      = 1'b0;

        is_alpha   = (b inside {[8'h61:8'h7A], [8'h41:8'h5A]});
        is_digit   = (b inside {[8'h30:8'h39]});
        is_space   = (b inside {[8'h09:8'h0D], CH_SPACE});
        len_grown  = (tok_len_reg < LEN_MAX) ? tok_len_reg + LEN_W'(1) : tok_len_reg;
        kw_prog_inc = kw_prog_reg + 4'd1;
        kw_match   = (kw_prog_reg < kw_len(kw_choice_reg)) &&
                     (b == kw_char(kw_choice_reg, kw_prog_reg));

        punct = 1'b1;
        case (b)
            CH_COMMA:    punct_kind = KIND_COMMA;
            CH_SEMI:     punct_kind = KIND_SEMI;
            CH_LPAREN:   punct_kind = KIND_LPAREN;
            CH_RPAREN:   punct_kind = KIND_RPAREN;
            CH_LBRACKET: punct_kind = KIND_LBRACKET;
            CH_RBRACKET: punct_kind = KIND_RBRACKET;
            CH_LBRACE:   punct_kind = KIND_LBRACE;
            CH_RBRACE:   punct_kind = KIND_RBRACE;
            default:
            begin
                punct      = 1'b0;
                punct_kind = KIND_UNKNOWN;
            end
        endcase

        if (accept && text.end_of_input)
        begin
            // End of input closes whatever is open, then reports itself.
            case (mode_reg)
                MODE_KEYWORD, MODE_IDENT:
                begin
                    emit_a = 1'b1;
                    tok_a  = '{KIND_IDENT, tok_start_reg, tok_len_reg, tok_line_reg, 1'b0};
                end
                MODE_STRING:
                begin
                    emit_a = 1'b1;
                    tok_a  = '{KIND_STRING, tok_start_reg, tok_len_reg, tok_line_reg, 1'b0};
                end
                default:
                begin
                end
            endcase
            emit_b = 1'b1;
            tok_b  = '{KIND_EOF, offset_reg, '0, line_count_reg,
                       (mode_reg == MODE_LINE || mode_reg == MODE_BLOCK ||
                        mode_reg == MODE_STAR)};
            mode_next    = MODE_IDLE;
            kw_prog_next = '0;
            esc_next     = 1'b0;
        end
        else if (accept)
        begin
            offset_next = offset_reg + OFFS_W'(1);
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (b == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (b == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                        go_idle = 1'b1;
                end
                MODE_LINE:
                begin
                    if (b == CH_NEWLINE)
                    begin
                        line_count_next = line_count_reg + LINE_W'(1);
                        mode_next       = MODE_IDLE;
                    end
                end
                MODE_BLOCK:
                begin
                    if (b == CH_STAR)
                        mode_next = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (b == CH_SLASH)
                        mode_next = MODE_IDLE;
                    else if (b != CH_STAR)
                        mode_next = MODE_BLOCK;
                end
                MODE_KEYWORD:
                begin
                    if (kw_match)
                    begin
                        kw_prog_next = kw_prog_inc;
                        tok_len_next = len_grown;
                        if (kw_prog_inc >= kw_len(kw_choice_reg))
                        begin
                            emit_a = 1'b1;
                            tok_a  = '{KIND_INTROSPECT + KIND_W'(kw_choice_reg), tok_start_reg,
                                       LEN_W'(kw_len(kw_choice_reg)), tok_line_reg, 1'b0};
                            mode_next    = MODE_IDLE;
                            kw_prog_next = '0;
                        end
                    end
                    else
                    begin
                        mode_next    = MODE_IDENT;
                        kw_prog_next = '0;
                        ident_path   = 1'b1;
                    end
                end
                MODE_IDENT:
                begin
                    ident_path = 1'b1;
                end
                MODE_STRING:
                begin
                    tok_len_next = len_grown;
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (b == CH_QUOTE)
                    begin
                        emit_a    = 1'b1;
                        tok_a     = '{KIND_STRING, tok_start_reg, len_grown, tok_line_reg, 1'b0};
                        mode_next = MODE_IDLE;
                    end
                    else if (b == CH_BSLASH)
                        esc_next = 1'b1;
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            // Identifier continues, or closes and hands the byte to idle.
            if (ident_path)
            begin
                if (is_alpha || is_digit || b == CH_UNDER)
                    tok_len_next = len_grown;
                else
                begin
                    emit_a  = 1'b1;
                    tok_a   = '{KIND_IDENT, tok_start_reg, tok_len_reg, tok_line_reg, 1'b0};
                    go_idle = 1'b1;
                end
            end

            // Byte lexed from the idle mode.
            if (go_idle)
            begin
                mode_next = MODE_IDLE;
                if (punct)
                begin
                    emit_b = 1'b1;
                    tok_b  = '{punct_kind, offset_reg, LEN_W'(1), line_count_reg, 1'b0};
                end
                else if (is_space)
                begin
                    if (b == CH_NEWLINE)
                        line_count_next = line_count_reg + LINE_W'(1);
                end
                else if (b == CH_SLASH)
                    mode_next = MODE_SLASH;
                else if (b == CH_QUOTE)
                begin
                    mode_next      = MODE_STRING;
                    tok_start_next = offset_reg + OFFS_W'(1);
                    tok_line_next  = line_count_reg;
                    tok_len_next   = '0;
                    esc_next       = 1'b0;
                end
                else if (is_alpha || b == CH_UNDER)
                begin
                    tok_start_next = offset_reg;
                    tok_line_next  = line_count_reg;
                    tok_len_next   = LEN_W'(1);
                    kw_prog_next   = 4'd1;
                    mode_next      = MODE_KEYWORD;
                    if (b == CH_I)
                        kw_choice_next = KW_INTROSPECT;
                    else if (b == CH_S)
                        kw_choice_next = KW_STRUCT;
                    else if (b == CH_E)
                        kw_choice_next = KW_ENUM;
                    else if (b == CH_U)
                        kw_choice_next = KW_UNION;
                    else
                        mode_next = MODE_IDENT;
                end
                else
                begin
                    emit_b = 1'b1;
                    tok_b  = '{KIND_UNKNOWN, offset_reg, LEN_W'(1), line_count_reg, 1'b0};
                end
            end
        end

        // A configuration write reloads the line counter.
        if (cfg.valid)
            line_count_next = LINE_W'(cfg.first_line);
    end

    // Pack the tokens of this byte into one queue entry, earliest first.
    always_comb
    begin
        push         = emit_a || emit_b;
        entry.two    = emit_a && emit_b;
        entry.first  = emit_a ? tok_a : tok_b;
        entry.second = tok_b;
    end

    // Lexer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            kw_prog_reg    <= '0;
            kw_choice_reg  <= '0;
            tok_start_reg  <= '0;
            tok_len_reg    <= '0;
            tok_line_reg   <= '0;
            offset_reg     <= '0;
            line_count_reg <= LINE_RESET;
            esc_reg        <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            kw_prog_reg    <= kw_prog_next;
            kw_choice_reg  <= kw_choice_next;
            tok_start_reg  <= tok_start_next;
            tok_len_reg    <= tok_len_next;
            tok_line_reg   <= tok_line_next;
            offset_reg     <= offset_next;
            line_count_reg <= line_count_next;
            esc_reg        <= esc_next;
        end
    end

    // End of input always leaves the lexer idle with no escape pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && text.end_of_input |=> mode_reg == MODE_IDLE && !esc_reg)
        else $error("lexer not idle after end of input");

    // A configuration write loads the line counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> line_count_reg == LINE_W'($past(cfg.first_line)))
        else $error("line counter not loaded by configuration write");

endmodule

`default_nettype wire

>>> rtl/clex_queue.sv
// Short queue of token entries between the lexer front end and the output
// stage. One push and one pop per cycle. Uses clex_pkg.
`default_nettype none

module clex_queue
    import clex_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire entry_t    push_entry,
    input  wire logic      pop,
    output entry_t         head,
    output q_status_t      status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    entry_t          mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    // The fill count never passes the depth, nothing is taken when empty and nothing is pushed when full.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH) && !(pop && status.empty) && !(push && status.full))
        else $error("queue overflow or underflow");

endmodule

`default_nettype wire

>>> rtl/clex_back.sv
// Output stage of the lexer: takes entries from the queue and hands out their
// tokens one per cycle on the token channel while the receiver is ready. Uses clex_pkg.
`default_nettype none

module clex_back
    import clex_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire entry_t    head,
    input  wire q_status_t q_stat,
    output logic           pop,
    clex_token_if.source   token
);

    logic   hold_valid_reg, hold_valid_next;
    entry_t hold_reg;
    logic   slot_reg, slot_next;
    logic   taken;
    logic   finish;
    token_t cur;

    assign taken  = token.valid && token.ready;
    // The held entry is done once its last token is taken.
    assign finish = taken && !(hold_reg.two && !slot_reg);
    assign pop    = (!hold_valid_reg || finish) && !q_stat.empty;

    // Hold register control.
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        slot_next       = slot_reg;
        if (pop)
        begin
            hold_valid_next = 1'b1;
            slot_next       = 1'b0;
        end
        else if (finish)
            hold_valid_next = 1'b0;
        else if (taken)
            slot_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            slot_reg       <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            slot_reg       <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            hold_reg <= head;
    end

    // Present the current token of the held entry.
    assign cur                   = slot_reg ? hold_reg.second : hold_reg.first;
    assign token.valid           = hold_valid_reg;
    assign token.token_kind      = cur.kind;
    assign token.start_offset    = cur.start;
    assign token.token_length    = cur.len;
    assign token.line_number     = cur.line;
    assign token.runaway_comment = cur.runaway;
    assign token.last_result     = !(hold_reg.two && !slot_reg);

    // The second slot is only ever shown for an entry that has two tokens.
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg && slot_reg |-> hold_reg.two)
        else $error("second token shown for a single-token entry");

endmodule

`default_nettype wire

>>> rtl/c_like_token_lexer.sv
// Top level of the C-like token lexer: front end, entry queue, output stage.
// Depends on clex_pkg, clex_if, clex_front, clex_queue and clex_back.
// Path: a byte's first token goes into the queue storage, then into the hold register of the
// output stage, which shows it; a second token of that byte is shown once the first is taken.
// Throughput: one byte and one token per cycle; input stalls only while the queue is full.
// Reset (rst_n, asynchronous, active low): lexer idle, offsets zero, line counter 1.
`default_nettype none

module c_like_token_lexer
    import clex_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = DEF_MAX_TOKEN_LEN,
    parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    clex_byte_if.sink    text,
    clex_cfg_if.sink     cfg,
    clex_token_if.source token
);

    logic      push;
    logic      pop;
    entry_t    push_entry;
    entry_t    head;
    q_status_t q_stat;

    clex_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .cfg    (cfg),
        .q_stat (q_stat),
        .push   (push),
        .entry  (push_entry)
    );

    clex_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_stat)
    );

    clex_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .token  (token)
    );

endmodule

`default_nettype wire
